// ----- rtl/core/dqs_pkg.sv -----
// Shared types and codes for the deque with value search.
// No dependencies; imported by the controller, datapath, top level and checker.
package dqs_pkg;

  // Request codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CONTAINS   = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;         // capture request, clear result flags
    logic exec;         // push/pop update, empty/full checks
    logic scan_start;   // scan pointer to front
    logic scan_run;     // issue one store read, advance pointer
    logic set_found;
    logic shift_start;  // scan pointer to one past the hit
    logic shift_wr;     // write returned entry one place toward front
    logic dec_count;
    logic rd_front;
    logic rd_back;
    logic cap_front;
    logic finish;       // load result registers, raise strobe
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic search_go;    // contains/remove on a non-empty queue
    logic is_remove;
    logic hit;          // returned entry matches the search value
    logic last;         // returned entry is the back element
  } sts_t;

endpackage

// ----- rtl/core/dqs_ctrl.sv -----
// Sequencing state machine for the deque with value search.
// Depends on dqs_pkg; drives dqs_datapath through cmd_t and reads sts_t.
module dqs_ctrl
  import dqs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FRONT = 3'd4;
  localparam logic [2:0] S_BACK  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = sts.search_go ? S_SCAN : S_FRONT;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.set_found = 1'b1;
          if (!sts.is_remove) begin
            state_nxt = S_FRONT;
          end else if (sts.last) begin
            // removing the back element: nothing to move
            cmd.dec_count = 1'b1;
            state_nxt     = S_FRONT;
          end else begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end
        end else if (sts.last) begin
          state_nxt = S_FRONT;
        end
      end
      S_SHIFT: begin
        cmd.scan_run = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.last) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_FRONT;
        end
      end
      S_FRONT: begin
        cmd.rd_front = 1'b1;
        state_nxt    = S_BACK;
      end
      S_BACK: begin
        cmd.rd_back   = 1'b1;
        cmd.cap_front = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/dqs_datapath.sv -----
// Element store, head/count registers, scan pipeline and result registers.
// Depends on dqs_pkg; sequenced by dqs_ctrl.
module dqs_datapath
  import dqs_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  input  logic [2:0]                    in_operation,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic signed [VALUE_WIDTH-1:0] out_front_value,
  output logic signed [VALUE_WIDTH-1:0] out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]    out_count,
  output logic                          out_is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [VALUE_WIDTH-1:0] mem_r [DEPTH];

  logic [2:0]             op_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [AW-1:0]          head_r,   head_nxt;
  logic [CW-1:0]          cnt_r,    cnt_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   found_r;
  logic [CW-1:0]          ptr_r;
  logic                   rv_r,     rv_nxt;
  logic [CW-1:0]          rv_idx_r;
  logic [VALUE_WIDTH-1:0] rdata_r;
  logic [VALUE_WIDTH-1:0] front_r;
  logic                   out_valid_r;

  logic                   full, empty;
  logic [AW-1:0]          head_dec, head_inc;
  logic [CW-1:0]          back_off;
  logic [AW-1:0]          raddr, waddr;
  logic                   we;
  logic [VALUE_WIDTH-1:0] wdata;

  // position of the element at a given offset from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, head} + {1'b0, off};
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[AW-1:0];
  endfunction

  assign full     = (cnt_r == DEPTH_C);
  assign empty    = (cnt_r == '0);
  assign head_dec = (head_r == '0) ? LAST_A : head_r - 1'b1;
  assign head_inc = (head_r == LAST_A) ? '0 : head_r + 1'b1;
  assign back_off = empty ? '0 : cnt_r - 1'b1;

  assign sts.search_go = ((op_r == OP_CONTAINS) || (op_r == OP_REMOVE)) && !empty;
  assign sts.is_remove = (op_r == OP_REMOVE);
  assign sts.hit       = rv_r && (rdata_r == val_r);
  assign sts.last      = rv_r && (rv_idx_r == back_off);

  // read port: front, back, or the scan pointer
  always_comb begin
    if (cmd.rd_front) begin
      raddr = slot_of(head_r, '0);
    end else if (cmd.rd_back) begin
      raddr = slot_of(head_r, back_off);
    end else begin
      raddr = slot_of(head_r, ptr_r);
    end
  end

  // push / pop updates and the shift write-back
  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = slot_of(head_r, rv_idx_r - 1'b1);
    wdata      = rdata_r;
    if (cmd.load) begin
      status_nxt = ST_OK;
    end
    if (cmd.exec) begin
      case (op_r)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            head_nxt = head_dec;
            cnt_nxt  = cnt_r + 1'b1;
            we       = 1'b1;
            waddr    = head_dec;
            wdata    = val_r;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            we      = 1'b1;
            waddr   = slot_of(head_r, cnt_r);
            wdata   = val_r;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        OP_CONTAINS, OP_REMOVE: begin
          if (empty) status_nxt = ST_EMPTY;
        end
        default: begin
        end
      endcase
    end
    if (cmd.shift_wr && rv_r) begin
      we = 1'b1;
    end
    if (cmd.dec_count) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign rv_nxt = cmd.shift_start ? 1'b0 :
                  cmd.scan_start  ? 1'b0 :
                  cmd.scan_run    ? (ptr_r < cnt_r) : rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (cmd.load) begin
      op_r    <= in_operation;
      val_r   <= in_value;
      found_r <= 1'b0;
    end else if (cmd.set_found) begin
      found_r <= 1'b1;
    end
    if (cmd.shift_start) begin
      ptr_r <= rv_idx_r + 1'b1;
    end else if (cmd.scan_start) begin
      ptr_r <= '0;
    end else if (cmd.scan_run && (ptr_r < cnt_r)) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.scan_run) rv_idx_r <= ptr_r;
    if (cmd.cap_front) front_r <= rdata_r;
    if (cmd.finish) begin
      out_status      <= status_r;
      out_found       <= found_r;
      out_front_value <= empty ? '0 : front_r;
      out_back_value  <= empty ? '0 : rdata_r;
      out_count       <= cnt_r;
      out_is_empty    <= empty;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/deque_with_value_search.sv -----
// Deque with value search: push/pop at both ends, contains, remove-first-match.
// Each transaction steps through load, execute, read front, read back and finish; contains
// and remove scan one stored entry per cycle between execute and read front, a rate
// set by the single read port of the element store. One transaction at a time: busy
// drops with out_valid, so a new request is accepted only once the last result is out.
// Synchronous reset empties the queue (store not cleared); out_valid strobes, no stall.
module deque_with_value_search
  import dqs_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_operation,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic signed [VALUE_WIDTH-1:0] out_front_value,
  output logic signed [VALUE_WIDTH-1:0] out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]    out_count,
  output logic                          out_is_empty
);

  cmd_t cmd;
  sts_t sts;

  dqs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  dqs_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty)
  );

endmodule

// ----- rtl/core/dqs_checker.sv -----
// Port-level checks for deque_with_value_search, attached by bind.
// Depends on dqs_pkg and the top level's port list.
module dqs_checker
  import dqs_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [1:0]                    out_status,
  input logic                          out_found,
  input logic signed [VALUE_WIDTH-1:0] out_front_value,
  input logic signed [VALUE_WIDTH-1:0] out_back_value,
  input logic [$clog2(DEPTH+1)-1:0]    out_count,
  input logic                          out_is_empty
);

  localparam logic [$clog2(DEPTH+1)-1:0] DEPTH_C = $clog2(DEPTH+1)'(DEPTH);

  // an accepted transaction holds the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // one result per transaction, never two strobes back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("consecutive result strobes");

  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)) && (out_count <= DEPTH_C))
    else $error("empty flag and count disagree");

  a_empty_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_back_value == '0))
    else $error("front/back nonzero on empty queue");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_status == ST_OK) && !out_is_empty ||
                               (out_status == ST_OK) && (out_count == '0))
    else $error("found with non-ok status");

endmodule

bind deque_with_value_search dqs_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_dqs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_count       (out_count),
  .out_is_empty    (out_is_empty)
);
